FILE: rtl/core/gtsd_pkg.sv
// Shared constants and codes for the gap tolerant stretch detector.
`default_nettype none

package gtsd_pkg;

	// Number of length histogram bins and the address width of the bin memory
	localparam int HIST_BINS = 1024;
	localparam int HIST_AW   = $clog2(HIST_BINS);

	localparam int POS_W   = 32;
	localparam int GAP_W   = 16;
	localparam int COUNT_W = 32;
	localparam int CFG_W   = 32;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_FLUSH  = 2'd1,
		OP_READ   = 2'd2
	} opcode_t;

	typedef enum logic {
		KIND_STRETCH = 1'b0,
		KIND_READ    = 1'b1
	} kind_t;

	typedef enum logic {
		REG_GAP_ALLOWED    = 1'b0,
		REG_START_POSITION = 1'b1
	} reg_index_t;

endpackage

`default_nettype wire

FILE: rtl/core/gap_tolerant_stretch_detector_unit.sv
// Top level of the gap tolerant stretch detector with its length histogram.
`default_nettype none

//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------------
//  item      | item_valid / item_ready    | opcode, sample, bin_index
//  result    | result_valid / result_ready| kind, stretch_start, stretch_end, bin_count
//  config    | cfg_write                  | cfg_index, cfg_data
//
//  One item per cycle sustained while results are taken. A result passes the stage 1
//  register (synchronous histogram read, source of the increment), then the output register.
//  After reset the histogram memory is swept to zero, one bin per cycle, so item_ready
//  stays low until the last bin is cleared; configuration writes are taken throughout.
//  When the output register is stalled and a result waits behind it, item_ready drops.
module gap_tolerant_stretch_detector_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  gtsd_pkg::reg_index_t     cfg_index,
	input  logic [gtsd_pkg::CFG_W-1:0] cfg_data,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  logic [1:0]               opcode,
	input  logic signed [15:0]       sample,
	input  logic [9:0]               bin_index,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic                     kind,
	output logic [31:0]              stretch_start,
	output logic [31:0]              stretch_end,
	output logic [31:0]              bin_count
);
	import gtsd_pkg::*;

	// Configuration registers
	logic [GAP_W-1:0] gap_allowed_q;
	logic [POS_W-1:0] start_position_q;

	// Scalar stream state
	logic [POS_W-1:0] pos_cnt_q;
	logic [GAP_W-1:0] gap_cnt_q;
	logic             open_q;
	logic [POS_W-1:0] open_start_q;
	logic [POS_W-1:0] open_end_q;

	// Histogram memory and the clearing sweep
	logic [COUNT_W-1:0] hist_mem [HIST_BINS];
	logic               clr_q;
	logic [HIST_AW-1:0] clr_addr_q;

	// Stage 1: read data back from the memory, increment computed here
	logic               valid_s1;
	kind_t              kind_s1;
	logic [POS_W-1:0]   start_s1;
	logic [POS_W-1:0]   end_s1;
	logic [HIST_AW-1:0] addr_s1;
	logic               in_range_s1;
	logic [COUNT_W-1:0] rd_s1;

	// Output register
	logic               out_valid_q;
	kind_t              kind_q;
	logic [POS_W-1:0]   start_q;
	logic [POS_W-1:0]   end_q;
	logic [COUNT_W-1:0] count_q;

	logic               accept;
	logic               advance_s1;
	logic               positive;
	logic [POS_W-1:0]   cur_pos;
	logic [POS_W-1:0]   stretch_len;
	logic [HIST_AW-1:0] len_bin;
	logic               close_now;
	logic               has_result;
	logic [HIST_AW-1:0] rd_addr;
	logic               mem_we;
	logic [HIST_AW-1:0] mem_waddr;
	logic [COUNT_W-1:0] mem_wdata;
	logic [COUNT_W-1:0] inc_count;

	// Stage 1 moves into the output register whenever that register is free or drained.
	assign advance_s1 = !out_valid_q || result_ready;
	// Hold off new items during the sweep, or when stage 1 cannot move on.
	assign item_ready = !clr_q && !(valid_s1 && !advance_s1);
	assign accept     = item_valid && item_ready;

	assign cur_pos     = start_position_q + pos_cnt_q;
	assign positive    = !sample[15] && (sample != 16'sd0);
	assign stretch_len = open_end_q - open_start_q;
	// Clamp long stretches into the last bin.
	assign len_bin     = (stretch_len >= POS_W'(HIST_BINS - 1)) ?
	                     HIST_AW'(HIST_BINS - 1) : stretch_len[HIST_AW-1:0];

	always_comb begin
		close_now  = 1'b0;
		has_result = 1'b0;
		case (opcode)
			OP_SAMPLE: begin
				close_now  = !positive && (gap_cnt_q > gap_allowed_q) && open_q;
				has_result = close_now;
			end
			OP_FLUSH: begin
				close_now  = open_q;
				has_result = open_q;
			end
			OP_READ: begin
				has_result = 1'b1;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	assign rd_addr = close_now ? len_bin : HIST_AW'(bin_index);

	// Saturating increment of the bin read for a closed stretch
	assign inc_count = (rd_s1 == '1) ? rd_s1 : rd_s1 + COUNT_W'(1);

	// One write port: the clearing sweep, else the write-back of stage 1.
	always_comb begin
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = valid_s1 && (kind_s1 == KIND_STRETCH);
			mem_waddr = addr_s1;
			mem_wdata = inc_count;
		end
	end

	// Histogram memory; a read that hits the bin written in the same cycle takes the new value.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_waddr] <= mem_wdata;
		end
		if (accept && has_result) begin
			rd_s1 <= (mem_we && (mem_waddr == rd_addr)) ? mem_wdata : hist_mem[rd_addr];
		end
	end

	// Clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + HIST_AW'(1);
			if (clr_addr_q == HIST_AW'(HIST_BINS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_allowed_q    <= '0;
			start_position_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GAP_ALLOWED:    gap_allowed_q    <= cfg_data[GAP_W-1:0];
				REG_START_POSITION: start_position_q <= cfg_data[POS_W-1:0];
				default:            gap_allowed_q    <= gap_allowed_q;
			endcase
		end
	end

	// Stream state: positions, gap count and the open stretch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_cnt_q    <= '0;
			gap_cnt_q    <= '0;
			open_q       <= 1'b0;
			open_start_q <= '0;
			open_end_q   <= '0;
		end else if (accept) begin
			case (opcode)
				OP_SAMPLE: begin
					pos_cnt_q <= pos_cnt_q + POS_W'(1);
					if (positive) begin
						gap_cnt_q  <= '0;
						open_end_q <= cur_pos;
						if (!open_q) begin
							open_start_q <= cur_pos;
							open_q       <= 1'b1;
						end
					end else if (gap_cnt_q > gap_allowed_q) begin
						gap_cnt_q <= '0;
						open_q    <= 1'b0;
					end else if (gap_cnt_q != '1) begin
						gap_cnt_q <= gap_cnt_q + GAP_W'(1);
					end
				end
				OP_FLUSH: begin
					pos_cnt_q <= '0;
					gap_cnt_q <= '0;
					open_q    <= 1'b0;
				end
				default: begin
					pos_cnt_q <= pos_cnt_q;
				end
			endcase
		end
	end

	// Stage 1 register: capture items that produce a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= has_result;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_result) begin
			kind_s1     <= close_now ? KIND_STRETCH : KIND_READ;
			start_s1    <= close_now ? open_start_q : '0;
			end_s1      <= close_now ? open_end_q : '0;
			addr_s1     <= rd_addr;
			in_range_s1 <= close_now || (32'(bin_index) < 32'(HIST_BINS));
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && valid_s1) begin
			kind_q  <= kind_s1;
			start_q <= start_s1;
			end_q   <= end_s1;
			count_q <= ((kind_s1 == KIND_READ) && in_range_s1) ? rd_s1 : '0;
		end
	end

	assign result_valid  = out_valid_q;
	assign kind          = kind_q;
	assign stretch_start = start_q;
	assign stretch_end   = end_q;
	assign bin_count     = count_q;

endmodule

`default_nettype wire

FILE: test/tb_gap_tolerant_stretch_detector_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the gap tolerant stretch detector unit.
module tb_gap_tolerant_stretch_detector_unit;
	import gtsd_pkg::*;

	localparam int         CLK_HALF_NS   = 6;
	localparam int         RESET_CYCLES  = 9;
	// Settle time after the last result: covers the stage 1 and output registers, with slack
	localparam int         SETTLE_CYCLES = 8;
	localparam int         DRAIN_LIMIT   = 20000;
	// Watchdog limit in ns, sized for the slowest correct run (the histogram sweep, the long
	// hold on the result side and the heavily throttled random phases)
	localparam longint     RUN_LIMIT_NS  = 64'd800_000 * 2 * CLK_HALF_NS;
	localparam int         REPORT_LIMIT  = 10;
	localparam logic [1:0] OP_UNUSED     = 2'd3;
	localparam logic [GAP_W-1:0]   GAP_SAT   = '1;
	localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

	typedef struct packed {
		kind_t              tag;
		logic [POS_W-1:0]   from_pos;
		logic [POS_W-1:0]   to_pos;
		logic [COUNT_W-1:0] bin_total;
	} detector_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_write;
	reg_index_t         cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               item_valid;
	logic               item_ready;
	logic [1:0]         opcode;
	logic signed [15:0] sample;
	logic [9:0]         bin_index;
	logic               result_valid;
	logic               result_ready;
	logic               kind;
	logic [31:0]        stretch_start;
	logic [31:0]        stretch_end;
	logic [31:0]        bin_count;

	// Predicted detector state: configuration, counters, open stretch, histogram
	logic [GAP_W-1:0]   gap_limit;
	logic [POS_W-1:0]   first_position;
	logic [POS_W-1:0]   position_count;
	logic [GAP_W-1:0]   gap_count;
	logic               stretch_is_open;
	logic [POS_W-1:0]   open_first;
	logic [POS_W-1:0]   open_last;
	logic [COUNT_W-1:0] length_bins [HIST_BINS];

	// Results still owed by the block, oldest first
	detector_result_t pending_results [$];
	int mismatch_count;

	// Traffic shaping knobs, changed by the tests
	int src_idle_pct;
	int sink_stall_pct;
	int sink_hold_cycles;

	gap_tolerant_stretch_detector_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.opcode        (opcode),
		.sample        (sample),
		.bin_index     (bin_index),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.kind          (kind),
		.stretch_start (stretch_start),
		.stretch_end   (stretch_end),
		.bin_count     (bin_count)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// Close the open stretch: bump its length bin (clamped, saturating) and
	// queue the start/end report.
	task automatic close_open_stretch();
		logic [POS_W-1:0] span;
		int               bin;
		span = open_last - open_first;
		bin = (span >= HIST_BINS - 1) ? HIST_BINS - 1 : int'(span);
		if (length_bins[bin] != COUNT_SAT)
			length_bins[bin] += 1;
		pending_results.push_back('{KIND_STRETCH, open_first, open_last, 32'd0});
		stretch_is_open = 1'b0;
	endtask

	// Advance the predicted state by one accepted item and queue its result, if any.
	task automatic advance_detector(input logic [1:0] op, input logic signed [15:0] smp,
			input logic [9:0] idx);
		logic [POS_W-1:0] here;
		here = first_position + position_count;
		case (op)
			OP_SAMPLE: begin
				if (smp > 0) begin
					// Positive score: open or extend, and forget the gap
					gap_count = '0;
					if (!stretch_is_open) begin
						open_first      = here;
						stretch_is_open = 1'b1;
					end
					open_last = here;
				end else if (gap_count > gap_limit) begin
					// Gap already too long: this non-positive sample ends the stretch
					gap_count = '0;
					if (stretch_is_open)
						close_open_stretch();
				end else if (gap_count != GAP_SAT) begin
					gap_count += 1;
				end
				position_count += 1;
			end
			OP_FLUSH: begin
				if (stretch_is_open)
					close_open_stretch();
				gap_count      = '0;
				position_count = '0;
			end
			OP_READ: begin
				pending_results.push_back('{KIND_READ, 32'd0, 32'd0,
					(idx < HIST_BINS) ? length_bins[idx] : 32'd0});
			end
			default: begin
				// Unused opcode: no result, no state change
			end
		endcase
	endtask

	function automatic logic signed [15:0] positive_score();
		return 16'($urandom_range(32767, 1));
	endfunction

	function automatic logic signed [15:0] non_positive_score();
		return 16'(-int'($urandom_range(32768)));
	endfunction

	task automatic set_pace(input int src_pct, input int sink_pct);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
	endtask

	// Offer one item on the falling edge, possibly after idle cycles, and hold it
	// until the block takes it. The prediction advances at the accepting edge.
	task automatic send_item(input logic [1:0] op, input logic signed [15:0] smp,
			input logic [9:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		opcode     <= op;
		sample     <= smp;
		bin_index  <= idx;
		do @(posedge clk); while (!item_ready);
		advance_detector(op, smp, idx);
	endtask

	// Write one register; only called with the block idle.
	task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_GAP_ALLOWED:    gap_limit      = value[GAP_W-1:0];
			REG_START_POSITION: first_position = value;
			default: ;
		endcase
	endtask

	// Drop valid, wait until every predicted result has come back, then let the
	// pipeline settle since samples may still be in flight with no result.
	task automatic wait_for_results();
		int waited;
		waited = 0;
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Field extremes, every opcode, ignored opcode, flush with and without an
	// open stretch, gap tolerance of one.
	task automatic test_directed_ops();
		set_pace(24, 70);
		write_reg(REG_GAP_ALLOWED, 32'd1);
		write_reg(REG_START_POSITION, 32'd100);
		send_item(OP_READ, 16'sd0, 10'd0);
		send_item(OP_READ, 16'sd0, 10'd1023);
		send_item(OP_UNUSED, 16'sh7FFF, 10'd1023);
		send_item(OP_SAMPLE, 16'sh7FFF, 10'd0);      // opens at 100
		send_item(OP_SAMPLE, 16'sd0, 10'd0);
		send_item(OP_SAMPLE, 16'sh8000, 10'd0);
		send_item(OP_SAMPLE, 16'sd1, 10'd0);         // extends to 103
		send_item(OP_SAMPLE, -16'sd1, 10'h3FF);
		send_item(OP_SAMPLE, 16'sd0, 10'd0);
		send_item(OP_SAMPLE, -16'sd5, 10'd0);        // gap exceeded: closes 100..103
		send_item(OP_READ, 16'sd0, 10'd3);
		send_item(OP_FLUSH, 16'sd0, 10'd0);          // nothing open
		send_item(OP_SAMPLE, 16'sd5, 10'd0);         // opens at 100 again
		send_item(OP_UNUSED, 16'sh8000, 10'd0);      // must not advance the position
		send_item(OP_SAMPLE, 16'sd9, 10'd0);
		send_item(OP_FLUSH, 16'sh8000, 10'h3FF);     // closes 100..101
		send_item(OP_READ, 16'sh7FFF, 10'd1);
		send_item(OP_SAMPLE, 16'sd77, 10'd0);
		send_item(OP_FLUSH, 16'sh7FFF, 10'd0);       // closes a single-position stretch
		send_item(OP_READ, 16'sh8000, 10'd0);
		wait_for_results();
	endtask

	// Positions wrap past 2^32 - 1; zero gap tolerance.
	task automatic test_position_wrap();
		write_reg(REG_GAP_ALLOWED, 32'd0);
		write_reg(REG_START_POSITION, 32'hFFFF_FFFE);
		repeat (4) send_item(OP_SAMPLE, positive_score(), 10'd0);
		send_item(OP_FLUSH, 16'sd0, 10'd0);          // closes FFFFFFFE..1
		send_item(OP_SAMPLE, positive_score(), 10'd0);
		send_item(OP_SAMPLE, 16'sd0, 10'd0);
		send_item(OP_SAMPLE, 16'sd0, 10'd0);         // second gap sample closes
		send_item(OP_READ, 16'sd0, 10'd3);
		wait_for_results();
		write_reg(REG_START_POSITION, 32'hFFFF_FFFF);
		send_item(OP_SAMPLE, positive_score(), 10'd0);
		send_item(OP_SAMPLE, positive_score(), 10'd0);
		send_item(OP_FLUSH, 16'sd0, 10'd0);
		send_item(OP_READ, 16'sd0, 10'd1);
		wait_for_results();
	endtask

	// Stretches of length just below, at and beyond the last bin, and one whose
	// length is close to 2^32. Move the position base while the stretch is open
	// so the second positive sample lands the full span past the first.
	task automatic test_long_stretches();
		logic [POS_W-1:0] spans [4];
		spans = '{32'd1022, 32'd1023, 32'd1500, 32'hFFFF_FF00};
		write_reg(REG_GAP_ALLOWED, 32'd65535);
		foreach (spans[i]) begin
			wait_for_results();
			write_reg(REG_START_POSITION, 32'd0);
			send_item(OP_SAMPLE, positive_score(), 10'd0);   // opens at 0
			wait_for_results();
			write_reg(REG_START_POSITION, spans[i] - 32'd1);
			send_item(OP_SAMPLE, positive_score(), 10'd0);   // extends to the span
			send_item(OP_FLUSH, 16'sd0, 10'd0);
		end
		send_item(OP_READ, 16'sd0, 10'd1022);
		send_item(OP_READ, 16'sd0, 10'd1023);
		wait_for_results();
	endtask

	// Hold the result side off for a long stretch while items keep coming, so the
	// block fills and drops item_ready; then pause until everything is back.
	task automatic test_backpressure();
		set_pace(0, 0);
		write_reg(REG_GAP_ALLOWED, 32'd2);
		@(posedge clk);
		sink_hold_cycles = 300;
		repeat (40) begin
			send_item(OP_READ, 16'sd0, 10'($urandom_range(7)));
			send_item(OP_SAMPLE, positive_score(), 10'd0);
			send_item(OP_SAMPLE, non_positive_score(), 10'd0);
		end
		wait_for_results();
		repeat (30) send_item(OP_READ, 16'sd0, 10'($urandom));
		wait_for_results();
	endtask

	// One phase of random traffic: mostly bursts of positive and non-positive
	// scores that form and close stretches, with flushes, reads and noise mixed in.
	task automatic run_random_phase(input int src_pct, input int sink_pct,
			input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] start, input int count);
		int               roll;
		int               burst_left;
		bit               burst_positive;
		logic signed [15:0] smp;
		logic [9:0]       idx;
		burst_left     = 0;
		burst_positive = 1'b0;
		wait_for_results();
		write_reg(REG_GAP_ALLOWED, gap);
		write_reg(REG_START_POSITION, start);
		set_pace(src_pct, sink_pct);
		repeat (count) begin
			roll = $urandom_range(99);
			idx  = 10'($urandom);
			smp  = 16'($urandom);
			if (roll < 5) begin
				send_item(OP_FLUSH, smp, idx);
			end else if (roll < 13) begin
				// Small bins are where the counts pile up
				if ($urandom_range(3) != 0)
					idx = 10'($urandom_range(15));
				send_item(OP_READ, smp, idx);
			end else if (roll < 15) begin
				send_item(OP_UNUSED, smp, idx);
			end else begin
				if (burst_left == 0) begin
					burst_positive = 1'($urandom_range(1));
					burst_left     = $urandom_range(12, 1);
				end
				burst_left--;
				if ($urandom_range(9) != 0)
					smp = burst_positive ? positive_score() : non_positive_score();
				send_item(OP_SAMPLE, smp, idx);
			end
		end
		wait_for_results();
	endtask

	task automatic test_random_streams();
		run_random_phase(24, 70, 32'd0, 32'hFFFF_FFF0, 450);
		run_random_phase(70, 24, $urandom_range(8, 1), $urandom, 450);
		run_random_phase(0, 0, 32'd3, 32'd0, 450);
	endtask

	// Result side: stall at random on the falling edge, or hold off entirely
	// while a test has asked for it.
	always @(negedge clk) begin
		if (sink_hold_cycles > 0) begin
			result_ready <= 1'b0;
			sink_hold_cycles--;
		end else begin
			result_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		detector_result_t seen;
		detector_result_t want;
		if (arst_n && result_valid && result_ready) begin
			seen = '{kind_t'(kind), stretch_start, stretch_end, bin_count};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("ERROR: unexpected result kind=%0d start=%h end=%h count=%0d",
						seen.tag, seen.from_pos, seen.to_pos, seen.bin_total);
			end else begin
				want = pending_results.pop_front();
				if (seen.tag != want.tag || seen.from_pos != want.from_pos ||
						seen.to_pos != want.to_pos || seen.bin_total != want.bin_total) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display({"ERROR: expected kind=%0d start=%h end=%h count=%0d,",
							" got kind=%0d start=%h end=%h count=%0d"},
							want.tag, want.from_pos, want.to_pos, want.bin_total,
							seen.tag, seen.from_pos, seen.to_pos, seen.bin_total);
				end
			end
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		cfg_write        = 1'b0;
		cfg_index        = REG_GAP_ALLOWED;
		cfg_data         = '0;
		item_valid       = 1'b0;
		opcode           = OP_SAMPLE;
		sample           = '0;
		bin_index        = '0;
		result_ready     = 1'b0;
		mismatch_count   = 0;
		sink_hold_cycles = 0;
		set_pace(24, 70);
		gap_limit        = '0;
		first_position   = '0;
		position_count   = '0;
		gap_count        = '0;
		stretch_is_open  = 1'b0;
		open_first       = '0;
		open_last        = '0;
		foreach (length_bins[i])
			length_bins[i] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The block sweeps its histogram after reset; send_item simply waits on ready
		test_directed_ops();
		test_position_wrap();
		test_long_stretches();
		test_backpressure();
		test_random_streams();

		wait_for_results();
		if (pending_results.size() != 0) begin
			mismatch_count += pending_results.size();
			$display("ERROR: %0d expected results never arrived", pending_results.size());
		end
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/gtsd_pkg.sv
rtl/core/gap_tolerant_stretch_detector_unit.sv
test/tb_gap_tolerant_stretch_detector_unit.sv
